// File: rtl/vnc_pkg.sv
`default_nettype none
package vnc_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int OCT_BITS    = 3;
  localparam int LANE_LAT    = 11;
  localparam int PIPE_LEN    = 17;

  // configuration register indexes
  localparam logic [3:0] CFG_NOISE_SEED   = 4'd0;
  localparam logic [3:0] CFG_INVERSE_ZOOM = 4'd1;
  localparam logic [3:0] CFG_PERSISTENCE  = 4'd2;
  localparam logic [3:0] CFG_OCTAVE_COUNT = 4'd3;
  localparam logic [3:0] CFG_TINT_RED     = 4'd4;
  localparam logic [3:0] CFG_TINT_GREEN   = 4'd5;
  localparam logic [3:0] CFG_TINT_BLUE    = 4'd6;
  localparam logic [3:0] CFG_MIX_WEIGHT   = 4'd7;

  localparam logic [31:0] HASH_MUL_A = 32'd60493;
  localparam logic [31:0] HASH_ADD_B = 32'd19990303;
  localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
  localparam logic [15:0] RECIP_255  = 16'd32897;
  localparam logic [7:0]  FADE_LIMIT = 8'd180;
  localparam logic [7:0]  RECIP_5    = 8'd205;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  typedef logic [15:0] cos_tab_t [256];

  // (1 - cos(pi*t/256)) / 2 in q1.15, sine series in q2.30, nine terms
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        tab;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sq;
    longint          s;
    for (int t = 0; t < 256; t++) begin
      theta = (PI_Q30 * longint'(t)) >> 9;
      x2    = (theta * theta) >> 30;
      term  = theta;
      s     = longint'(theta);
      term = ((term * x2) >> 30) / 64'd6;   s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  s = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  s = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; s = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd210; s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd272; s = s + longint'(term);
      if (s < 0) s = 0;
      if (s > ONE_Q30) s = ONE_Q30;
      sq = longint'(s) * longint'(s);
      tab[t] = 16'((sq + (64'd1 << 44)) >> 45);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_W_TAB = build_cos_tab();

  typedef struct packed {
    logic [OCT_BITS-1:0] oct;
    logic [25:0]         cx_base;
    logic [25:0]         cy_base;
    logic [31:0]         seed;
    logic [16:0]         amp;
  } lane_in_t;

endpackage
`default_nettype wire

// File: rtl/vnc_lane.sv
`default_nettype none
module vnc_lane
  import vnc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire lane_in_t           lin,
  output logic signed [35:0]      contrib_r
);

  logic [31:0]        cx, cy;
  logic [15:0]        x0_r;
  logic [31:0]        ys0_r;
  logic [31:0]        seed1_r;
  logic               ymax_r;
  logic [15:0]        wx_r [6];
  logic [15:0]        wy_r [8];
  logic [31:0]        n_r [4];
  logic [31:0]        n3_r [4];
  logic [31:0]        n4_r [4];
  logic [31:0]        sq_r [4];
  logic [31:0]        p_r [4];
  logic [31:0]        m_r [4];
  logic signed [17:0] val [4];
  logic signed [17:0] v0_r, v2_r, dt_r, db_r;
  logic signed [17:0] v0b_r, v2b_r;
  logic signed [35:0] pt_r, pb_r;
  logic signed [17:0] top_r, bot_r, top9_r, noise_r;
  logic signed [35:0] py_r;
  logic [15:0]        x1;
  logic [31:0]        ys1;
  logic [31:0]        nc [4];

  assign cx  = 32'({6'd0, lin.cx_base} << lin.oct);
  assign cy  = 32'({6'd0, lin.cy_base} << lin.oct);
  assign x1  = x0_r + 16'd1;
  // the next lattice row wraps to zero after the last one
  assign ys1 = ymax_r ? 32'd0 : ys0_r + seed1_r;

  always_comb begin
    nc[0] = {16'd0, x0_r} + ys0_r;
    nc[1] = {16'd0, x1}   + ys0_r;
    nc[2] = {16'd0, x0_r} + ys1;
    nc[3] = {16'd0, x1}   + ys1;
    for (int i = 0; i < 4; i++) begin
      val[i] = 18'sd32768 - $signed({2'b0, m_r[i][30:15]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // lattice row product and cosine weights
      x0_r    <= cx[31:16];
      ys0_r   <= 32'(cy[31:16]) * lin.seed;
      seed1_r <= lin.seed;
      ymax_r  <= &cy[31:16];
      wx_r[0] <= COS_W_TAB[cx[15:8]];
      wy_r[0] <= COS_W_TAB[cy[15:8]];
      for (int i = 1; i < 6; i++) wx_r[i] <= wx_r[i-1];
      for (int i = 1; i < 8; i++) wy_r[i] <= wy_r[i-1];
      // hash of the four corners
      for (int i = 0; i < 4; i++) begin
        n_r[i]  <= nc[i] ^ (nc[i] << 13);
        sq_r[i] <= n_r[i] * n_r[i];
        n3_r[i] <= n_r[i];
        p_r[i]  <= sq_r[i] * HASH_MUL_A + HASH_ADD_B;
        n4_r[i] <= n3_r[i];
        m_r[i]  <= n4_r[i] * p_r[i] + HASH_ADD_C;
      end
      // interpolation in x
      v0_r  <= val[0];
      v2_r  <= val[2];
      dt_r  <= val[1] - val[0];
      db_r  <= val[3] - val[2];
      pt_r  <= dt_r * $signed({2'b0, wx_r[5]});
      pb_r  <= db_r * $signed({2'b0, wx_r[5]});
      v0b_r <= v0_r;
      v2b_r <= v2_r;
      top_r <= v0b_r + 18'(pt_r >>> 15);
      bot_r <= v2b_r + 18'(pb_r >>> 15);
      // interpolation in y
      py_r   <= (bot_r - top_r) * $signed({2'b0, wy_r[7]});
      top9_r <= top_r;
      noise_r <= top9_r + 18'(py_r >>> 15);
      // amplitude is taken from the config side at the last stage
      contrib_r <= noise_r * $signed({1'b0, lin.amp});
    end
  end

endmodule
`default_nettype wire

// File: rtl/value_noise_cloud_texel.sv
// Cloud texel generator. func 0 sums up to eight octaves of 2D value noise
// (hashed lattice, cosine interpolation, persistence-weighted amplitudes),
// maps the sum to an intensity 0..255 used as alpha and as the tint scale,
// and optionally blends with previous_texel by mix_weight. func 1 fades the
// alpha of previous_texel (below 180 becomes alpha/5). One texel enters per
// clock unless stalled; the result is registered through the hash multiply
// chain and interpolation in each octave lane, then the sum and color stages.
// out_stall freezes the whole pipeline while out_valid is high. Config writes
// take effect at once (cfg_ready is always high); write them only while idle.
`default_nettype none
module value_noise_cloud_texel
  import vnc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [9:0]  in_pixel_x,
  input  wire logic [9:0]  in_pixel_y,
  input  wire logic [31:0] in_previous_texel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_texel_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [31:0] seed_r;
  logic [15:0] izoom_r;
  logic [15:0] persist_r;
  logic [3:0]  octs_r;
  logic [7:0]  tint_r_r, tint_g_r, tint_b_r;
  logic [8:0]  mix_r;

  // pipeline control: every stage moves when the output is free
  logic en;
  logic vld_r [PIPE_LEN];
  logic func_r [PIPE_LEN];
  logic [31:0] prev_r [PIPE_LEN];
  logic out_valid_r;
  logic [31:0] out_texel_r;

  logic [25:0] cxb_r, cyb_r;
  logic [16:0] amp_r [MAX_OCTAVES];
  logic signed [35:0] contrib [MAX_OCTAVES];
  logic [3:0]  octs_eff;
  logic signed [35:0] gated [MAX_OCTAVES];
  logic signed [37:0] sum4_r [4];
  logic signed [37:0] sum2_r [2];
  logic signed [39:0] bias_r;
  logic [7:0]  inten;
  logic [7:0]  inten_r;
  logic [15:0] rp_r, gp_r, bp_r;
  logic [31:0] texel_r;
  logic [31:0] rq, gq, bq;
  logic        do_mix;
  logic [31:0] mixed;
  logic [31:0] faded;
  logic [15:0] fade_q;
  logic [8:0]  mix_inv;
  logic [16:0] bsum [4];

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_texel_out = out_texel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= '0;
      izoom_r   <= 16'd3641;
      persist_r <= 16'd3277;
      octs_r    <= 4'd1;
      tint_r_r  <= 8'd200;
      tint_g_r  <= 8'd200;
      tint_b_r  <= 8'd200;
      mix_r     <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NOISE_SEED:   seed_r    <= cfg_data;
        CFG_INVERSE_ZOOM: izoom_r   <= cfg_data[15:0];
        CFG_PERSISTENCE:  persist_r <= cfg_data[15:0];
        CFG_OCTAVE_COUNT: octs_r    <= cfg_data[3:0];
        CFG_TINT_RED:     tint_r_r  <= cfg_data[7:0];
        CFG_TINT_GREEN:   tint_g_r  <= cfg_data[7:0];
        CFG_TINT_BLUE:    tint_b_r  <= cfg_data[7:0];
        CFG_MIX_WEIGHT:   mix_r     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // amplitude per octave, a register chain that settles after a persistence
  // write before a newly transferred item reaches the lane multiply
  always_ff @(posedge clk) begin
    amp_r[0] <= 17'd65536;
    for (int i = 1; i < MAX_OCTAVES; i++) begin
      amp_r[i] <= 17'((33'(amp_r[i-1]) * 33'(persist_r)) >> 16);
    end
  end

  // valid bits and side payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LEN; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_LEN; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r[0] <= in_func;
      prev_r[0] <= in_previous_texel;
      for (int i = 1; i < PIPE_LEN; i++) begin
        func_r[i] <= func_r[i-1];
        prev_r[i] <= prev_r[i-1];
      end
      // q16.16 base coordinates
      cxb_r <= in_pixel_x * izoom_r;
      cyb_r <= in_pixel_y * izoom_r;
    end
  end

  // one lane per octave, all in parallel
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
    lane_in_t lin;
    assign lin = {OCT_BITS'(g), cxb_r, cyb_r, seed_r, amp_r[g]};
    vnc_lane u_lane (
      .clk       (clk),
      .en        (en),
      .lin       (lin),
      .contrib_r (contrib[g])
    );
  end

  // octave count clamps at the lane count
  assign octs_eff = (octs_r > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octs_r;

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      gated[i] = (4'(i) < octs_eff) ? contrib[i] : '0;
    end
  end

  // saturated intensity
  always_comb begin
    if (bias_r < 0) inten = 8'd0;
    else if (bias_r[39:24] > 16'd255) inten = 8'd255;
    else inten = bias_r[31:24];
  end

  // divide by 255 through reciprocal, exact for 16-bit products
  assign rq = rp_r * RECIP_255;
  assign gq = gp_r * RECIP_255;
  assign bq = bp_r * RECIP_255;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sum4_r[i] <= 38'(gated[2*i]) + 38'(gated[2*i+1]);
      end
      sum2_r[0] <= sum4_r[0] + sum4_r[1];
      sum2_r[1] <= sum4_r[2] + sum4_r[3];
      bias_r    <= 40'(sum2_r[0]) + 40'(sum2_r[1]) + 40'sd2147483648;
      inten_r   <= inten;
      rp_r      <= tint_r_r * inten;
      gp_r      <= tint_g_r * inten;
      bp_r      <= tint_b_r * inten;
      texel_r   <= {inten_r, rq[30:23], gq[30:23], bq[30:23]};
    end
  end

  // blend with previous texel, or fade on func 1
  assign do_mix  = (mix_r != 9'd0) && !mix_r[8];
  assign mix_inv = 9'd256 - mix_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bsum[i] = 17'(texel_r[8*i +: 8]) * 17'(mix_r)
              + 17'(prev_r[PIPE_LEN-1][8*i +: 8]) * 17'(mix_inv)
              + 17'd128;
      mixed[8*i +: 8] = bsum[i][15:8];
    end
    fade_q = prev_r[PIPE_LEN-1][31:24] * RECIP_5;
    faded  = prev_r[PIPE_LEN-1];
    if (prev_r[PIPE_LEN-1][31:24] < FADE_LIMIT) faded[31:24] = {2'b0, fade_q[15:10]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (func_r[PIPE_LEN-1]) out_texel_r <= faded;
      else if (do_mix) out_texel_r <= mixed;
      else out_texel_r <= texel_r;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import vnc_pkg::*;

  // register index outside the list, must be ignored
  localparam logic [3:0] CFG_UNUSED_IDX = 4'd12;

  // texel request as it enters the generator
  typedef struct {
    logic        func;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [31:0] prev;
  } texel_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [9:0]  in_pixel_x = '0;
  logic [9:0]  in_pixel_y = '0;
  logic [31:0] in_previous_texel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_texel_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  value_noise_cloud_texel dut (.*);

  always #10 clk = ~clk;

  // shadow copy of the generator's registers
  logic [31:0] sh_seed;
  logic [15:0] sh_izoom;
  logic [15:0] sh_persist;
  logic [3:0]  sh_octaves;
  logic [7:0]  sh_tint_r, sh_tint_g, sh_tint_b;
  logic [8:0]  sh_mix;

  texel_req_t  pending_reqs[$];
  logic [31:0] expected_texels[$];
  int          fail_count = 0;
  int          texels_seen = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_send = 1'b0;
  logic [15:0] wtab [256];

  // cosine blend weight, q1.15, from a sine series in q2.30
  function automatic logic [15:0] cos_blend_weight(int t);
    longint unsigned th, x2, term;
    longint          s;
    th = (64'd3373259426 * longint'(t)) >> 9;
    x2 = (th * th) >> 30;
    term = th;
    s = longint'(th);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return 16'((64'(s) * 64'(s) + (64'd1 << 44)) >> 45);
  endfunction

  function automatic longint hash_value(logic [31:0] ix, logic [31:0] iy);
    logic [31:0] n, m;
    n = ix + iy * sh_seed;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
    return 64'sd32768 - longint'(m >> 15);
  endfunction

  // a + floor((b - a) * w / 32768)
  function automatic longint blend_q15(longint a, longint b, longint w);
    return a + ((b - a) * w >>> 15);
  endfunction

  function automatic logic [31:0] predict_texel(texel_req_t r);
    logic [31:0] cx, cy, x0, y0, x1, y1, amp, texel, res;
    longint      acc, top, bot, wx, wy, v;
    int          octs;
    logic [7:0]  alpha, inten, rr, gg, bb;
    if (r.func) begin
      alpha = r.prev[31:24];
      if (alpha < 8'd180) alpha = alpha / 8'd5;
      return {alpha, r.prev[23:0]};
    end
    octs = (sh_octaves > 4'd8) ? 8 : int'(sh_octaves);
    acc = 0;
    amp = 32'd65536;
    for (int a = 0; a < octs; a++) begin
      cx = (32'(r.px) * 32'(sh_izoom)) << a;
      cy = (32'(r.py) * 32'(sh_izoom)) << a;
      x0 = cx >> 16;
      y0 = cy >> 16;
      x1 = (x0 + 1) & 32'hffff;
      y1 = (y0 + 1) & 32'hffff;
      wx = longint'(wtab[cx[15:8]]);
      wy = longint'(wtab[cy[15:8]]);
      top = blend_q15(hash_value(x0, y0), hash_value(x1, y0), wx);
      bot = blend_q15(hash_value(x0, y1), hash_value(x1, y1), wx);
      acc += blend_q15(top, bot, wy) * longint'(amp);
      amp = 32'((64'(amp) * 64'(sh_persist)) >> 16);
    end
    v = acc + (64'sd128 << 24);
    if (v < 0) inten = 8'd0;
    else inten = ((v >>> 24) > 255) ? 8'd255 : 8'(v >>> 24);
    rr = 8'((16'(sh_tint_r) * 16'(inten)) / 16'd255);
    gg = 8'((16'(sh_tint_g) * 16'(inten)) / 16'd255);
    bb = 8'((16'(sh_tint_b) * 16'(inten)) / 16'd255);
    texel = {inten, rr, gg, bb};
    if (sh_mix > 9'd0 && sh_mix < 9'd256) begin
      for (int s = 0; s < 32; s += 8)
        res[s+:8] = 8'((32'(texel[s+:8]) * sh_mix + 32'(r.prev[s+:8]) * (32'd256 - sh_mix)
                        + 32'd128) >> 8);
      texel = res;
    end
    return texel;
  endfunction

  // driver: one transfer per cycle when not idling or stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_texels.push_back(predict_texel('{in_func, in_pixel_x, in_pixel_y,
                                                  in_previous_texel}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid          <= 1'b1;
          in_func           <= pending_reqs[0].func;
          in_pixel_x        <= pending_reqs[0].px;
          in_pixel_y        <= pending_reqs[0].py;
          in_previous_texel <= pending_reqs[0].prev;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        texels_seen++;
        if (expected_texels.size() == 0) begin
          $display("%0t: unexpected texel, expected none, got %h", $time, out_texel_out);
          fail_count++;
        end else begin
          if (out_texel_out !== expected_texels[0]) begin
            $display("%0t: texel_out mismatch, expected %h, got %h", $time,
                     expected_texels[0], out_texel_out);
            fail_count++;
          end
          void'(expected_texels.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NOISE_SEED:   sh_seed    = val;
      CFG_INVERSE_ZOOM: sh_izoom   = val[15:0];
      CFG_PERSISTENCE:  sh_persist = val[15:0];
      CFG_OCTAVE_COUNT: sh_octaves = val[3:0];
      CFG_TINT_RED:     sh_tint_r  = val[7:0];
      CFG_TINT_GREEN:   sh_tint_g  = val[7:0];
      CFG_TINT_BLUE:    sh_tint_b  = val[7:0];
      CFG_MIX_WEIGHT:   sh_mix     = val[8:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] seed, logic [15:0] iz, logic [15:0] pers,
                           logic [3:0] octs, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [8:0] mix);
    write_reg(CFG_NOISE_SEED, seed);
    write_reg(CFG_INVERSE_ZOOM, 32'(iz));
    write_reg(CFG_PERSISTENCE, 32'(pers));
    write_reg(CFG_OCTAVE_COUNT, 32'(octs));
    write_reg(CFG_TINT_RED, 32'(r));
    write_reg(CFG_TINT_GREEN, 32'(g));
    write_reg(CFG_TINT_BLUE, 32'(b));
    write_reg(CFG_MIX_WEIGHT, 32'(mix));
  endtask

  // wait for the pipeline to empty, then an idle margin
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_texels.size() > 0)
      @(posedge clk);
    repeat (PIPE_LEN + 8) @(posedge clk);
  endtask

  task automatic queue_req(logic f, logic [9:0] x, logic [9:0] y, logic [31:0] p);
    texel_req_t r;
    r.func = f; r.px = x; r.py = y; r.prev = p;
    pending_reqs.push_back(r);
  endtask

  // mostly generate requests, some fades; coordinates uniform over the full range
  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_req($urandom_range(3) == 0, 10'($urandom), 10'($urandom), $urandom);
  endtask

  initial begin
    for (int t = 0; t < 256; t++) wtab[t] = cos_blend_weight(t);
    sh_seed = 0; sh_izoom = 16'd3641; sh_persist = 16'd3277; sh_octaves = 4'd1;
    sh_tint_r = 8'd200; sh_tint_g = 8'd200; sh_tint_b = 8'd200; sh_mix = 9'd256;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes, fade boundary
    queue_req(1'b0, 10'd0, 10'd0, 32'h0);
    queue_req(1'b0, 10'h3ff, 10'h3ff, 32'hffffffff);
    queue_req(1'b0, 10'h3ff, 10'd0, 32'h12345678);
    queue_req(1'b1, 10'h3ff, 10'h3ff, 32'hb3aabbcc);
    queue_req(1'b1, 10'd0, 10'd0, 32'hb4aabbcc);
    queue_req(1'b1, 10'd5, 10'd9, 32'h00ffffff);
    queue_req(1'b1, 10'd5, 10'd9, 32'hff000000);
    queue_req(1'b1, 10'd0, 10'd0, 32'h09010203);
    drain();

    // directed: many octaves, partial blend, zero zoom
    write_all(32'hffffffff, 16'hffff, 16'hffff, 4'd8, 8'd255, 8'd0, 8'd128, 9'd128);
    queue_req(1'b0, 10'h3ff, 10'h3ff, 32'hffffffff);
    queue_req(1'b0, 10'd1, 10'd2, 32'h00000000);
    queue_req(1'b0, 10'd512, 10'd700, 32'h80808080);
    drain();
    write_all(32'd12345, 16'd0, 16'd0, 4'd15, 8'd0, 8'd255, 8'd255, 9'd1);
    queue_req(1'b0, 10'd77, 10'd900, 32'hffffffff);
    queue_req(1'b0, 10'h3ff, 10'h3ff, 32'h0);
    drain();
    write_all(32'h9e3779b9, 16'd1, 16'd65535, 4'd0, 8'd10, 8'd20, 8'd30, 9'd255);
    queue_req(1'b0, 10'd300, 10'd3, 32'h55aa55aa);
    drain();
    write_reg(CFG_MIX_WEIGHT, 32'd0);
    queue_req(1'b0, 10'd300, 10'd3, 32'h55aa55aa);
    drain();
    write_reg(CFG_OCTAVE_COUNT, 32'd9);
    write_reg(CFG_MIX_WEIGHT, 32'h1ff);
    write_reg(CFG_UNUSED_IDX, 32'hdeadbeef);
    queue_req(1'b0, 10'd300, 10'd3, 32'h55aa55aa);
    queue_req(1'b0, 10'd31, 10'd1000, 32'h0);
    drain();

    // random phases across idling patterns and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      write_all($urandom, 16'($urandom_range(65535, 1)), 16'($urandom),
                4'($urandom_range(8, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                9'($urandom_range(256)));
      queue_random(35);
      // hold off the sender until everything in flight has come back
      while (pending_reqs.size() > 0) @(posedge clk);
      hold_send = 1'b1;
      while (in_valid || expected_texels.size() > 0) @(posedge clk);
      hold_send = 1'b0;
      queue_random(33);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("covered %0d texels: both functions, eight register settings plus extremes,",
             texels_seen);
    $display("with sender gaps and receiver stalls in separate and combined phases");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
